@@ rtl/primary_ring_selector_defines.svh @@
// assertion macros shared by the ring selector modules
`ifndef PRIMARY_RING_SELECTOR_DEFINES_SVH
`define PRIMARY_RING_SELECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define PRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// consequence checked in the cycle after the condition
`define PRS_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> conseq) \
        else $error(msg);
`else
`define PRS_ASSERT(label, prop, msg)
`define PRS_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

@@ rtl/prs_pkg.sv @@
// shared types and constants of the primary ring selector
package prs_pkg;

    localparam int AREA_BITS  = 64;
    localparam int INDEX_BITS = 10;

    localparam logic [2:0] MIN_RING_VERTICES = 3'd4;

    typedef enum logic {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } t_cfg_reg;

    typedef logic signed [AREA_BITS-1:0] t_area;

    typedef struct packed {
        t_area term;
        logic  cross_prev;
        logic  cross_close;
        logic  ring_end;
        logic  set_end;
        logic  long_ring;
    } t_edge_info;

    typedef struct packed {
        t_area area;
        logic  holds;
        logic  set_end;
    } t_ring_info;

endpackage

@@ rtl/prs_edge.sv @@
// edge stage: shoelace term and crossing tests, registered
module prs_edge #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_prev_x,
    input  logic signed [COORD_BITS-1:0] i_prev_y,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic                         i_has_edge,
    input  logic                         i_ring_end,
    input  logic                         i_set_end,
    input  logic                         i_long_ring,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    output logic                         o_valid,
    input  logic                         i_ready,
    output prs_pkg::t_edge_info          o_info
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 2;
    localparam int AW = 2 * COORD_BITS;

    logic signed [COORD_BITS-1:0] ax [2];
    logic signed [COORD_BITS-1:0] ay [2];
    logic signed [COORD_BITS-1:0] bx [2];
    logic signed [COORD_BITS-1:0] by [2];
    logic [1:0]                   crosses;

    logic signed [AW-1:0]   prod_a;
    logic signed [AW-1:0]   prod_b;
    prs_pkg::t_area         term;
    prs_pkg::t_edge_info    n_info;
    logic                   take;

    logic                   r_valid;
    prs_pkg::t_edge_info    r_info;

    // edge 0: current to previous vertex, edge 1: first to current vertex
    assign ax[0] = i_x;
    assign ay[0] = i_y;
    assign bx[0] = i_prev_x;
    assign by[0] = i_prev_y;
    assign ax[1] = i_first_x;
    assign ay[1] = i_first_y;
    assign bx[1] = i_x;
    assign by[1] = i_y;

    for (genvar g = 0; g < 2; g++) begin : g_cross
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] cxa;
        logic signed [DW-1:0] bxa;
        logic signed [DW-1:0] cya;
        logic signed [PW-1:0] lhs;
        logic signed [PW-1:0] rhs;
        logic                 straddle;

        assign straddle = (ay[g] > i_center_y) != (by[g] > i_center_y);
        assign dy  = DW'(by[g]) - DW'(ay[g]);
        assign cxa = DW'(i_center_x) - DW'(ax[g]);
        assign bxa = DW'(bx[g]) - DW'(ax[g]);
        assign cya = DW'(i_center_y) - DW'(ay[g]);
        assign lhs = PW'(cxa) * PW'(dy);
        assign rhs = PW'(bxa) * PW'(cya);
        assign crosses[g] = straddle && ((dy > 0) ? (lhs < rhs) : (lhs > rhs));
    end

    assign prod_a = AW'(i_prev_x) * AW'(i_y);
    assign prod_b = AW'(i_x) * AW'(i_prev_y);
    assign term   = prs_pkg::t_area'(prod_a) - prs_pkg::t_area'(prod_b);

    always_comb begin
        n_info.term        = i_has_edge ? term : '0;
        n_info.cross_prev  = i_has_edge & crosses[0];
        n_info.cross_close = i_ring_end & crosses[1];
        n_info.ring_end    = i_ring_end;
        n_info.set_end     = i_set_end;
        n_info.long_ring   = i_long_ring;
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take || (r_valid && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_info <= n_info;
        end
    end

    assign o_valid = r_valid;
    assign o_info  = r_info;

endmodule

@@ rtl/prs_accum.sv @@
// ring accumulator: saturating area sum and crossing parity
`include "primary_ring_selector_defines.svh"

module prs_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  prs_pkg::t_edge_info i_info,
    output logic                o_valid,
    input  logic                i_ready,
    output prs_pkg::t_ring_info o_ring
);

    localparam int AB = prs_pkg::AREA_BITS;

    logic signed [AB:0]  wide_sum;
    prs_pkg::t_area      sat_sum;
    logic                parity_new;
    logic                parity_fin;
    logic                take;
    prs_pkg::t_ring_info n_ring;

    logic                r_valid;
    prs_pkg::t_area      r_sum;
    logic                r_parity;
    prs_pkg::t_ring_info r_ring;

    assign wide_sum = (AB+1)'(r_sum) + (AB+1)'(i_info.term);

    always_comb begin
        if (wide_sum[AB] != wide_sum[AB-1]) begin
            sat_sum = wide_sum[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
        end else begin
            sat_sum = wide_sum[AB-1:0];
        end
    end

    assign parity_new = r_parity ^ i_info.cross_prev;
    assign parity_fin = parity_new ^ i_info.cross_close;

    always_comb begin
        n_ring.area    = i_info.long_ring ? sat_sum : '0;
        n_ring.holds   = i_info.long_ring & parity_fin;
        n_ring.set_end = i_info.set_end;
    end

    // only a ring end needs room downstream
    assign o_ready = !i_info.ring_end || !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_sum    <= '0;
            r_parity <= 1'b0;
        end else begin
            r_valid <= (take && i_info.ring_end) || (r_valid && !i_ready);
            if (take) begin
                if (i_info.ring_end) begin
                    r_sum    <= '0;
                    r_parity <= 1'b0;
                end else begin
                    r_sum    <= sat_sum;
                    r_parity <= parity_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_info.ring_end) begin
            r_ring <= n_ring;
        end
    end

    assign o_valid = r_valid;
    assign o_ring  = r_ring;

    `PRS_ASSERT_NEXT(a_ring_held, r_valid && !i_ready, r_valid && $stable(r_ring), "ring lost")
    `PRS_ASSERT_NEXT(a_clear, take && i_info.ring_end, r_sum == '0 && !r_parity, "ring kept")

endmodule

@@ rtl/prs_choose.sv @@
// primary ring choice and result register
`include "primary_ring_selector_defines.svh"

module prs_choose #(
    parameter int MAX_RINGS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  prs_pkg::t_ring_info                i_ring,
    output logic                               o_valid,
    input  logic                               i_out_ready,
    output logic [prs_pkg::INDEX_BITS-1:0]     o_ring_number,
    output logic signed [prs_pkg::AREA_BITS-1:0] o_ring_twice_area,
    output logic                               o_ring_holds_center,
    output logic [prs_pkg::INDEX_BITS-1:0]     o_chosen_ring,
    output logic                               o_chosen_needs_reverse,
    output logic                               o_chosen_holds_center,
    output logic                               o_final_choice
);

    localparam int RW = $clog2(MAX_RINGS);
    localparam int AB = prs_pkg::AREA_BITS;
    localparam int IB = prs_pkg::INDEX_BITS;
    localparam logic [RW-1:0] LAST_RING = RW'(MAX_RINGS - 1);

    logic          neg;
    logic [AB-1:0] mag;
    logic          upd_in;
    logic          upd_any;
    logic          n_in_found;
    logic [RW-1:0] n_in_idx;
    logic [AB-1:0] n_in_mag;
    logic          n_in_neg;
    logic [RW-1:0] n_any_idx;
    logic [AB-1:0] n_any_mag;
    logic          n_any_neg;
    logic [RW-1:0] ch_idx;
    logic          ch_neg;
    logic          take;

    logic          r_out_valid;
    logic [RW-1:0] r_cnt;
    logic          r_in_found;
    logic [RW-1:0] r_in_idx;
    logic [AB-1:0] r_in_mag;
    logic          r_in_neg;
    logic          r_any_found;
    logic [RW-1:0] r_any_idx;
    logic [AB-1:0] r_any_mag;
    logic          r_any_neg;

    logic [IB-1:0]          r_out_ring;
    logic signed [AB-1:0]   r_out_area;
    logic                   r_out_ring_in;
    logic [IB-1:0]          r_out_ch_idx;
    logic                   r_out_ch_neg;
    logic                   r_out_ch_in;
    logic                   r_out_final;

    assign neg = i_ring.area[AB-1];
    assign mag = neg ? (AB'(0) - i_ring.area) : i_ring.area;

    // earlier ring keeps the choice on equal magnitude
    assign upd_in  = i_ring.holds && (!r_in_found || (mag > r_in_mag));
    assign upd_any = !r_any_found || (mag > r_any_mag);

    always_comb begin
        n_in_found = r_in_found | upd_in;
        n_in_idx   = upd_in ? r_cnt : r_in_idx;
        n_in_mag   = upd_in ? mag : r_in_mag;
        n_in_neg   = upd_in ? neg : r_in_neg;
        n_any_idx  = upd_any ? r_cnt : r_any_idx;
        n_any_mag  = upd_any ? mag : r_any_mag;
        n_any_neg  = upd_any ? neg : r_any_neg;
        ch_idx     = n_in_found ? n_in_idx : n_any_idx;
        ch_neg     = n_in_found ? n_in_neg : n_any_neg;
    end

    assign o_ready = !r_out_valid || i_out_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_in_found  <= 1'b0;
            r_any_found <= 1'b0;
        end else begin
            r_out_valid <= take || (r_out_valid && !i_out_ready);
            if (take) begin
                if (i_ring.set_end) begin
                    r_cnt       <= '0;
                    r_in_found  <= 1'b0;
                    r_any_found <= 1'b0;
                end else begin
                    r_cnt       <= (r_cnt == LAST_RING) ? '0 : r_cnt + RW'(1);
                    r_in_found  <= n_in_found;
                    r_any_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_idx      <= n_in_idx;
            r_in_mag      <= n_in_mag;
            r_in_neg      <= n_in_neg;
            r_any_idx     <= n_any_idx;
            r_any_mag     <= n_any_mag;
            r_any_neg     <= n_any_neg;
            r_out_ring    <= IB'(r_cnt);
            r_out_area    <= i_ring.area;
            r_out_ring_in <= i_ring.holds;
            r_out_ch_idx  <= IB'(ch_idx);
            r_out_ch_neg  <= ch_neg;
            r_out_ch_in   <= n_in_found;
            r_out_final   <= i_ring.set_end;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_ring_number          = r_out_ring;
    assign o_ring_twice_area      = r_out_area;
    assign o_ring_holds_center    = r_out_ring_in;
    assign o_chosen_ring          = r_out_ch_idx;
    assign o_chosen_needs_reverse = r_out_ch_neg;
    assign o_chosen_holds_center  = r_out_ch_in;
    assign o_final_choice         = r_out_final;

    `PRS_ASSERT(a_inside_has_any, r_in_found |-> r_any_found, "inside choice without any choice")
    `PRS_ASSERT(a_in_chosen, r_out_valid && r_out_ring_in |-> r_out_ch_in, "choice lost")
    `PRS_ASSERT_NEXT(a_set_clr, take && i_ring.set_end, !r_any_found && r_cnt == '0, "set kept")

endmodule

@@ rtl/primary_ring_selector.sv @@
// primary ring selector top level: config, vertex tracking and stage chain
// a ring end result shows after the input, edge, accumulator and choice registers
// throughput: one vertex request per cycle, set by the area and parity
// accumulator loop; a stalled result backs up through the stage registers, then stops input
// reset: synchronous, clears center point, ring state, ring counter and choice state
module primary_ring_selector #(
    parameter int MAX_RINGS  = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [COORD_BITS-1:0]                i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [COORD_BITS-1:0]         i_vertex_x,
    input  logic signed [COORD_BITS-1:0]         i_vertex_y,
    input  logic                                 i_ring_end,
    input  logic                                 i_set_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [prs_pkg::INDEX_BITS-1:0]       o_ring_number,
    output logic signed [prs_pkg::AREA_BITS-1:0] o_ring_twice_area,
    output logic                                 o_ring_holds_center,
    output logic [prs_pkg::INDEX_BITS-1:0]       o_chosen_ring,
    output logic                                 o_chosen_needs_reverse,
    output logic                                 o_chosen_holds_center,
    output logic                                 o_final_choice
);

    logic                         accept;
    logic                         edge_ready;
    logic                         edge_valid;
    logic                         accum_ready;
    logic                         accum_valid;
    logic                         choose_ready;
    prs_pkg::t_edge_info          edge_info;
    prs_pkg::t_ring_info          ring_info;
    logic [2:0]                   n_tally;
    logic signed [COORD_BITS-1:0] n_first_x;
    logic signed [COORD_BITS-1:0] n_first_y;

    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    logic [2:0]                   r_tally;
    logic signed [COORD_BITS-1:0] r_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y;
    logic signed [COORD_BITS-1:0] r_first_x;
    logic signed [COORD_BITS-1:0] r_first_y;

    logic                         r_s1_valid;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;
    logic signed [COORD_BITS-1:0] r_s1_px;
    logic signed [COORD_BITS-1:0] r_s1_py;
    logic signed [COORD_BITS-1:0] r_s1_fx;
    logic signed [COORD_BITS-1:0] r_s1_fy;
    logic                         r_s1_has_edge;
    logic                         r_s1_ring_end;
    logic                         r_s1_set_end;
    logic                         r_s1_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            unique case (prs_pkg::t_cfg_reg'(i_cfg_index))
                prs_pkg::CFG_CENTER_X: r_center_x <= $signed(i_cfg_data);
                prs_pkg::CFG_CENTER_Y: r_center_y <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid || edge_ready;

    always_comb begin
        n_tally   = (r_tally == prs_pkg::MIN_RING_VERTICES) ? r_tally : r_tally + 3'd1;
        n_first_x = (r_tally == 3'd0) ? i_vertex_x : r_first_x;
        n_first_y = (r_tally == 3'd0) ? i_vertex_y : r_first_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally    <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !edge_ready);
            if (accept) begin
                r_tally   <= i_ring_end ? 3'd0 : n_tally;
                r_prev_x  <= i_vertex_x;
                r_prev_y  <= i_vertex_y;
                r_first_x <= n_first_x;
                r_first_y <= n_first_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x        <= i_vertex_x;
            r_s1_y        <= i_vertex_y;
            r_s1_px       <= r_prev_x;
            r_s1_py       <= r_prev_y;
            r_s1_fx       <= n_first_x;
            r_s1_fy       <= n_first_y;
            r_s1_has_edge <= (r_tally != 3'd0);
            r_s1_ring_end <= i_ring_end;
            r_s1_set_end  <= i_ring_end & i_set_end;
            r_s1_long     <= (n_tally == prs_pkg::MIN_RING_VERTICES);
        end
    end

    prs_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .o_ready     (edge_ready),
        .i_x         (r_s1_x),
        .i_y         (r_s1_y),
        .i_prev_x    (r_s1_px),
        .i_prev_y    (r_s1_py),
        .i_first_x   (r_s1_fx),
        .i_first_y   (r_s1_fy),
        .i_has_edge  (r_s1_has_edge),
        .i_ring_end  (r_s1_ring_end),
        .i_set_end   (r_s1_set_end),
        .i_long_ring (r_s1_long),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .o_valid     (edge_valid),
        .i_ready     (accum_ready),
        .o_info      (edge_info)
    );

    prs_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (edge_valid),
        .o_ready (accum_ready),
        .i_info  (edge_info),
        .o_valid (accum_valid),
        .i_ready (choose_ready),
        .o_ring  (ring_info)
    );

    prs_choose #(
        .MAX_RINGS (MAX_RINGS)
    ) u_choose (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (accum_valid),
        .o_ready                (choose_ready),
        .i_ring                 (ring_info),
        .o_valid                (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_ring_number          (o_ring_number),
        .o_ring_twice_area      (o_ring_twice_area),
        .o_ring_holds_center    (o_ring_holds_center),
        .o_chosen_ring          (o_chosen_ring),
        .o_chosen_needs_reverse (o_chosen_needs_reverse),
        .o_chosen_holds_center  (o_chosen_holds_center),
        .o_final_choice         (o_final_choice)
    );

endmodule

@@ dv/prs_tb_pkg.sv @@
`timescale 1ns / 1ps
// ring report predictor and result checker for the primary ring selector bench
package prs_tb_pkg;

    localparam int     RING_LIMIT = 1024;
    localparam longint AREA_MAX   = 64'sh7fff_ffff_ffff_ffff;
    localparam longint AREA_MIN   = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [prs_pkg::INDEX_BITS-1:0]       ring_number;
        logic signed [prs_pkg::AREA_BITS-1:0] dbl_area;
        logic                                 holds_center;
        logic [prs_pkg::INDEX_BITS-1:0]       chosen_ring;
        logic                                 needs_reverse;
        logic                                 chosen_holds;
        logic                                 final_choice;
    } t_ring_report;

    class ring_tracker;
        longint       center_x, center_y;
        longint       prev_x, prev_y, first_x, first_y;
        int           tally;
        longint       area_sum;
        bit           parity;
        int           ring_idx;
        int           inside_idx;
        bit [63:0]    inside_mag;
        bit           inside_neg, inside_found;
        int           any_idx;
        bit [63:0]    any_mag;
        bit           any_neg, any_found;
        t_ring_report reports[$];
        int           mismatches;

        function new();
            center_x   = 0;
            center_y   = 0;
            mismatches = 0;
            clear_ring();
            clear_set();
        endfunction

        function void clear_ring();
            prev_x   = 0;
            prev_y   = 0;
            first_x  = 0;
            first_y  = 0;
            tally    = 0;
            area_sum = 0;
            parity   = 0;
        endfunction

        function void clear_set();
            ring_idx     = 0;
            inside_idx   = 0;
            inside_mag   = 0;
            inside_neg   = 0;
            inside_found = 0;
            any_idx      = 0;
            any_mag      = 0;
            any_neg      = 0;
            any_found    = 0;
        endfunction

        function void set_center(prs_pkg::t_cfg_reg which, logic signed [23:0] value);
            if (which == prs_pkg::CFG_CENTER_X) begin
                center_x = value;
            end else begin
                center_y = value;
            end
        endfunction

        function longint sat_sum(longint a, longint b);
            if (b > 0 && a > AREA_MAX - b) return AREA_MAX;
            if (b < 0 && a < AREA_MIN - b) return AREA_MIN;
            return a + b;
        endfunction

        // exact crossing test of edge a-b against the ray from the center
        function bit crosses(longint ax, longint ay, longint bx, longint by);
            longint d, lhs, rhs;
            if ((ay > center_y) == (by > center_y)) return 0;
            d   = by - ay;
            lhs = (center_x - ax) * d;
            rhs = (bx - ax) * (center_y - ay);
            return (d > 0) ? (lhs < rhs) : (lhs > rhs);
        endfunction

        function int pending();
            return reports.size();
        endfunction

        function void note_vertex(logic signed [23:0] vx, logic signed [23:0] vy,
                                  logic ring_end, logic set_end);
            longint       x, y, area;
            bit           holds, neg;
            bit [63:0]    mag;
            t_ring_report r;
            x = vx;
            y = vy;
            if (tally == 0) begin
                first_x = x;
                first_y = y;
            end else begin
                area_sum = sat_sum(area_sum, prev_x * y - x * prev_y);
                if (crosses(x, y, prev_x, prev_y)) parity = !parity;
            end
            if (tally < prs_pkg::MIN_RING_VERTICES) tally++;
            prev_x = x;
            prev_y = y;
            if (!ring_end) return;

            if (crosses(first_x, first_y, x, y)) parity = !parity;
            if (tally >= prs_pkg::MIN_RING_VERTICES) begin
                area  = area_sum;
                holds = parity;
            end else begin
                area  = 0;
                holds = 0;
            end
            neg = area < 0;
            mag = neg ? -area : area;

            if (holds && (!inside_found || mag > inside_mag)) begin
                inside_found = 1;
                inside_idx   = ring_idx;
                inside_mag   = mag;
                inside_neg   = neg;
            end
            if (!any_found || mag > any_mag) begin
                any_found = 1;
                any_idx   = ring_idx;
                any_mag   = mag;
                any_neg   = neg;
            end

            r.ring_number  = 10'(ring_idx);
            r.dbl_area     = area;
            r.holds_center = holds;
            if (inside_found) begin
                r.chosen_ring   = 10'(inside_idx);
                r.needs_reverse = inside_neg;
                r.chosen_holds  = 1'b1;
            end else begin
                r.chosen_ring   = 10'(any_idx);
                r.needs_reverse = any_neg;
                r.chosen_holds  = 1'b0;
            end
            r.final_choice = set_end;
            reports.insert(reports.size(), r);

            clear_ring();
            if (set_end) begin
                clear_set();
            end else begin
                ring_idx++;
                if (ring_idx >= RING_LIMIT) ring_idx = 0;
            end
        endfunction

        function void match_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_ring_report got);
            t_ring_report want;
            if (reports.size() == 0) begin
                $display("%0t: result with no request waiting, expected none actual ring %0d",
                         $time, got.ring_number);
                mismatches++;
                return;
            end
            want = reports.pop_front();
            match_field("ring_number", want.ring_number, got.ring_number);
            match_field("ring_twice_area", want.dbl_area, got.dbl_area);
            match_field("ring_holds_center", want.holds_center, got.holds_center);
            match_field("chosen_ring", want.chosen_ring, got.chosen_ring);
            match_field("chosen_needs_reverse", want.needs_reverse, got.needs_reverse);
            match_field("chosen_holds_center", want.chosen_holds, got.chosen_holds);
            match_field("final_choice", want.final_choice, got.final_choice);
        endfunction
    endclass

endpackage

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// top level bench of the primary ring selector: stimulus, handshakes and final verdict
module tb;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int WRAP_RINGS    = 1030;
    localparam int RANDOM_ITEMS  = 60;
    localparam int HOLD_CYCLES   = 400;

    localparam logic signed [23:0] COORD_MAX = 24'sh7fffff;
    localparam logic signed [23:0] COORD_MIN = 24'sh800000;

    typedef enum int {SPAN_NEAR, SPAN_MID, SPAN_FULL, SPAN_EDGE} t_span;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic                                 i_cfg_index = 1'b0;
    logic [23:0]                          i_cfg_data  = '0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 o_in_ready;
    logic signed [23:0]                   i_vertex_x  = '0;
    logic signed [23:0]                   i_vertex_y  = '0;
    logic                                 i_ring_end  = 1'b0;
    logic                                 i_set_end   = 1'b0;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic [prs_pkg::INDEX_BITS-1:0]       o_ring_number;
    logic signed [prs_pkg::AREA_BITS-1:0] o_ring_twice_area;
    logic                                 o_ring_holds_center;
    logic [prs_pkg::INDEX_BITS-1:0]       o_chosen_ring;
    logic                                 o_chosen_needs_reverse;
    logic                                 o_chosen_holds_center;
    logic                                 o_final_choice;

    prs_tb_pkg::ring_tracker tracker = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int sent_items    = 0;

    primary_ring_selector u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_vertex_x             (i_vertex_x),
        .i_vertex_y             (i_vertex_y),
        .i_ring_end             (i_ring_end),
        .i_set_end              (i_set_end),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_ring_number          (o_ring_number),
        .o_ring_twice_area      (o_ring_twice_area),
        .o_ring_holds_center    (o_ring_holds_center),
        .o_chosen_ring          (o_chosen_ring),
        .o_chosen_needs_reverse (o_chosen_needs_reverse),
        .o_chosen_holds_center  (o_chosen_holds_center),
        .o_final_choice         (o_final_choice)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side
    initial begin
        prs_tb_pkg::t_ring_report got;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.ring_number   = o_ring_number;
                got.dbl_area      = o_ring_twice_area;
                got.holds_center  = o_ring_holds_center;
                got.chosen_ring   = o_chosen_ring;
                got.needs_reverse = o_chosen_needs_reverse;
                got.chosen_holds  = o_chosen_holds_center;
                got.final_choice  = o_final_choice;
                tracker.check_result(got);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_vertex(input logic signed [23:0] x, input logic signed [23:0] y,
                               input logic ring_end, input logic set_end);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_vertex_x <= x;
        i_vertex_y <= y;
        i_ring_end <= ring_end;
        i_set_end  <= set_end;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_vertex(x, y, ring_end, set_end);
        sent_items++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_center(input logic signed [23:0] cx, input logic signed [23:0] cy);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= prs_pkg::CFG_CENTER_X;
        i_cfg_data  <= cx;
        @(posedge i_clk);
        tracker.set_center(prs_pkg::CFG_CENTER_X, cx);
        i_cfg_index <= prs_pkg::CFG_CENTER_Y;
        i_cfg_data  <= cy;
        @(posedge i_clk);
        tracker.set_center(prs_pkg::CFG_CENTER_Y, cy);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [23:0] pick_coord(t_span span, longint base);
        case (span)
            SPAN_NEAR: return 24'(base + longint'($urandom_range(16)) - 8);
            SPAN_MID:  return 24'(base + longint'($urandom_range(8192)) - 4096);
            SPAN_FULL: return 24'($urandom);
            default: begin
                case ($urandom_range(3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 24'(base);
                    default: return 24'sd0;
                endcase
            end
        endcase
    endfunction

    task automatic send_random_ring();
        int                 n, pick;
        bit                 closed;
        t_span              span;
        logic signed [23:0] fx, fy, vx, vy;
        n      = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
        closed = ($urandom_range(3) != 0);
        pick   = $urandom_range(99);
        span   = (pick < 35) ? SPAN_NEAR : (pick < 60) ? SPAN_MID :
                 (pick < 85) ? SPAN_FULL : SPAN_EDGE;
        fx     = '0;
        fy     = '0;
        for (int k = 0; k < n; k++) begin
            if (k == n - 1 && closed && n > 1) begin
                vx = fx;
                vy = fy;
            end else begin
                vx = pick_coord(span, tracker.center_x);
                vy = pick_coord(span, tracker.center_y);
            end
            if (k == 0) begin
                fx = vx;
                fy = vy;
            end
            if (k == n - 1) begin
                send_vertex(vx, vy, 1'b1, $urandom_range(5) == 0);
            end else begin
                send_vertex(vx, vy, 1'b0, $urandom_range(19) == 0);
            end
        end
    endtask

    task automatic run_random(input int target);
        int start;
        start = sent_items;
        while (sent_items - start < target) send_random_ring();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_center(24'sd0, 24'sd0);

        // single vertex, short ring, closed triangle
        send_vertex(24'sd5, 24'sd5, 1'b1, 1'b0);
        send_vertex(-24'sd10, -24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd10, -24'sd10, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd10, 1'b1, 1'b0);
        send_vertex(-24'sd100, -24'sd100, 1'b0, 1'b0);
        send_vertex(24'sd100, -24'sd100, 1'b0, 1'b0);
        send_vertex(24'sd0, 24'sd100, 1'b0, 1'b0);
        send_vertex(-24'sd100, -24'sd100, 1'b1, 1'b0);
        // clockwise square, set end without ring end is ignored
        send_vertex(-24'sd200, -24'sd200, 1'b0, 1'b0);
        send_vertex(-24'sd200, 24'sd200, 1'b0, 1'b1);
        send_vertex(24'sd200, 24'sd200, 1'b0, 1'b0);
        send_vertex(24'sd200, -24'sd200, 1'b0, 1'b0);
        send_vertex(-24'sd200, -24'sd200, 1'b1, 1'b0);
        // larger ring away from the center
        send_vertex(24'sd1000, 24'sd1000, 1'b0, 1'b0);
        send_vertex(24'sd2000, 24'sd1000, 1'b0, 1'b0);
        send_vertex(24'sd2000, 24'sd2000, 1'b0, 1'b0);
        send_vertex(24'sd1000, 24'sd2000, 1'b0, 1'b0);
        send_vertex(24'sd1000, 24'sd1000, 1'b1, 1'b0);
        // equal area tie
        send_vertex(-24'sd200, -24'sd200, 1'b0, 1'b0);
        send_vertex(-24'sd200, 24'sd200, 1'b0, 1'b0);
        send_vertex(24'sd200, 24'sd200, 1'b0, 1'b0);
        send_vertex(24'sd200, -24'sd200, 1'b0, 1'b0);
        send_vertex(-24'sd200, -24'sd200, 1'b1, 1'b0);
        // unclosed extreme square ends the set
        send_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1, 1'b1);

        // ring counter wrap
        for (int r = 0; r < WRAP_RINGS; r++) begin
            if (r == 1025) begin
                send_vertex(-24'sd50, -24'sd50, 1'b0, 1'b0);
                send_vertex(24'sd50, -24'sd50, 1'b0, 1'b0);
                send_vertex(24'sd50, 24'sd50, 1'b0, 1'b0);
                send_vertex(-24'sd50, -24'sd50, 1'b1, 1'b0);
            end else begin
                send_vertex(24'($urandom), 24'($urandom), 1'b1, r == WRAP_RINGS - 1);
            end
        end
        drain_results();

        write_center(COORD_MAX, COORD_MIN);
        send_idle_pct = 87;
        stall_pct     = 0;
        run_random(RANDOM_ITEMS);
        drain_results();

        write_center(COORD_MIN, COORD_MAX);
        send_idle_pct = 0;
        stall_pct     = 87;
        run_random(RANDOM_ITEMS);
        drain_results();

        write_center(24'($urandom), 24'($urandom));
        send_idle_pct = 32;
        stall_pct     = 32;
        run_random(RANDOM_ITEMS);
        drain_results();

        // receiver holds off while requests keep coming
        write_center(24'($urandom_range(2000)) - 24'sd1000, 24'($urandom_range(2000)) - 24'sd1000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = HOLD_CYCLES;
        for (int r = 0; r < 40; r++) begin
            send_vertex(24'($urandom), 24'($urandom), 1'b1, 1'b0);
        end
        drain_results();
        run_random(RANDOM_ITEMS);
        drain_results();

        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
